// ===== rtl/rrt_tree_extend_top_macros.svh =====
`ifndef RRT_TREE_EXTEND_TOP_MACROS_SVH
`define RRT_TREE_EXTEND_TOP_MACROS_SVH

// Check that holds in the same cycle as the trigger.
`define RTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after the trigger.
`define RTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rte_pkg.sv =====
package rte_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES) + 1;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int SQ_W      = 66;
    localparam int LIM2_W    = 62;
    localparam int ROOT_W    = 34;
    localparam int REM_W     = 37;
    localparam int PROD_W    = 64;
    localparam int DREM_W    = 35;
    localparam int LVL_W     = 11;
    localparam int STEP_W    = 31;
    localparam int OUT_IDX_W = 10;

    localparam logic [LVL_W-1:0] LVL_MAX = 11'd2047;

    // sequencer lengths
    localparam int DRAIN_CYC  = 3;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = PROD_W;

    // coordinate select
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_X    = 3'd0;
    localparam logic [2:0] REG_START_Y    = 3'd1;
    localparam logic [2:0] REG_START_Z    = 3'd2;
    localparam logic [2:0] REG_STEP_LIMIT = 3'd3;
    localparam logic [2:0] REG_GOAL_MIN_X = 3'd4;
    localparam logic [2:0] REG_GOAL_MAX_X = 3'd5;
    localparam logic [2:0] REG_GOAL_MIN_Y = 3'd6;
    localparam logic [2:0] REG_GOAL_MAX_Y = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic [STEP_W-1:0]         step_limit;
        logic signed [COORD_W-1:0] goal_min_x;
        logic signed [COORD_W-1:0] goal_max_x;
        logic signed [COORD_W-1:0] goal_min_y;
        logic signed [COORD_W-1:0] goal_max_y;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             scan_issue;
        logic [IDX_W-1:0] scan_idx;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             mul;
        logic             div_load;
        logic             div_step;
        logic             div_store;
        logic [1:0]       comp;
        logic             copy_sample;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] node_cnt;
        logic             steer;
        logic             out_busy;
    } stat_t;

endpackage

// ===== rtl/rte_regs.sv =====
module rte_regs
    import rte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x    <= '0;
            cfg_reg.start_y    <= '0;
            cfg_reg.start_z    <= '0;
            cfg_reg.step_limit <= STEP_W'(65536);
            cfg_reg.goal_min_x <= '0;
            cfg_reg.goal_max_x <= '0;
            cfg_reg.goal_min_y <= '0;
            cfg_reg.goal_max_y <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_X:    cfg_reg.start_x    <= pwdata;
                REG_START_Y:    cfg_reg.start_y    <= pwdata;
                REG_START_Z:    cfg_reg.start_z    <= pwdata;
                REG_STEP_LIMIT: cfg_reg.step_limit <= pwdata[STEP_W-1:0];
                REG_GOAL_MIN_X: cfg_reg.goal_min_x <= pwdata;
                REG_GOAL_MAX_X: cfg_reg.goal_max_x <= pwdata;
                REG_GOAL_MIN_Y: cfg_reg.goal_min_y <= pwdata;
                REG_GOAL_MAX_Y: cfg_reg.goal_max_y <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_START_X:    prdata = cfg_reg.start_x;
            REG_START_Y:    prdata = cfg_reg.start_y;
            REG_START_Z:    prdata = cfg_reg.start_z;
            REG_STEP_LIMIT: prdata = {1'b0, cfg_reg.step_limit};
            REG_GOAL_MIN_X: prdata = cfg_reg.goal_min_x;
            REG_GOAL_MAX_X: prdata = cfg_reg.goal_max_x;
            REG_GOAL_MIN_Y: prdata = cfg_reg.goal_min_y;
            REG_GOAL_MAX_Y: prdata = cfg_reg.goal_max_y;
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rte_ctrl.sv =====
module rte_ctrl
    import rte_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_DRAIN  = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_SQRT   = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_LOAD   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_STORE  = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= COMP_X;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_idx   = cnt_reg[IDX_W-1:0];
                if (cnt_reg == stat.node_cnt - CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == CNT_W'(DRAIN_CYC - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                cnt_next = '0;
                if (stat.steer) begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                end else begin
                    cmd.copy_sample = 1'b1;
                    state_next      = ST_FIN;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    comp_next  = COMP_X;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_STORE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_STORE: begin
                cmd.div_store = 1'b1;
                if (comp_reg == COMP_Z) begin
                    state_next = ST_FIN;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rte_dp.sv =====
`include "rrt_tree_extend_top_macros.svh"

module rte_dp
    import rte_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [COORD_W-1:0]  sample_x,
    input  logic [COORD_W-1:0]  sample_y,
    input  logic [COORD_W-1:0]  sample_z,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata
);

    // node table
    logic [COORD_W-1:0] mem_x   [MAX_NODES];
    logic [COORD_W-1:0] mem_y   [MAX_NODES];
    logic [COORD_W-1:0] mem_z   [MAX_NODES];
    logic [LVL_W-1:0]   mem_lvl [MAX_NODES];

    logic [CNT_W-1:0] node_cnt_reg;

    logic signed [COORD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [LIM2_W-1:0]         lim2_reg;

    // scan pipeline
    logic                      v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]          idx1_reg, idx2_reg, idx3_reg;
    logic [COORD_W-1:0]        rd_x_reg, rd_y_reg, rd_z_reg;
    logic [LVL_W-1:0]          rd_lvl_reg;
    logic signed [COORD_W-1:0] px1, py1, pz1;
    logic [LVL_W-1:0]          lvl1;
    logic signed [DIFF_W-1:0]  dx1, dy1, dz1;
    logic [DIFF_W-1:0]         ax2_reg, ay2_reg, az2_reg;
    logic [COORD_W-1:0]        px2_reg, py2_reg, pz2_reg;
    logic [LVL_W-1:0]          lvl2_reg;
    logic [SQ_W-1:0]           sqx3_reg, sqy3_reg, sqz3_reg;
    logic [COORD_W-1:0]        px3_reg, py3_reg, pz3_reg;
    logic [LVL_W-1:0]          lvl3_reg;
    logic [SQ_W-1:0]           sum3;

    // nearest node so far
    logic [SQ_W-1:0]           best_d2_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg, bz_reg;
    logic [LVL_W-1:0]          best_lvl_reg;

    // root unit
    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh, trial;

    // steering divide
    logic signed [COORD_W-1:0] bsel, ssel;
    logic signed [DIFF_W-1:0]  dsel;
    logic [DIFF_W-1:0]         asel;
    logic [PROD_W-1:0]         prod_reg, dq_reg;
    logic                      neg_reg;
    logic [DREM_W-1:0]         drem_reg, dtry;
    logic signed [DIFF_W:0]    qs, nsum;
    logic signed [COORD_W-1:0] nx_reg, ny_reg, nz_reg;

    // result
    logic                      full_w, hit_w;
    logic [LVL_W-1:0]          depth_w;
    logic                      m_valid_reg;
    logic [OUT_IDX_W-1:0]      o_idx_reg, o_par_reg;
    logic [COORD_W-1:0]        o_x_reg, o_y_reg, o_z_reg;
    logic [LVL_W-1:0]          o_depth_reg;
    logic                      o_hit_reg, o_full_reg;

    // sample capture and squared step limit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg   <= sample_x;
            sy_reg   <= sample_y;
            sz_reg   <= sample_z;
            lim2_reg <= LIM2_W'(cfg.step_limit) * LIM2_W'(cfg.step_limit);
        end
    end

    // table read, registered
    always_ff @(posedge aclk) begin
        if (cmd.scan_issue) begin
            rd_x_reg   <= mem_x[cmd.scan_idx];
            rd_y_reg   <= mem_y[cmd.scan_idx];
            rd_z_reg   <= mem_z[cmd.scan_idx];
            rd_lvl_reg <= mem_lvl[cmd.scan_idx];
        end
    end

    // table write on completion
    always_ff @(posedge aclk) begin
        if (cmd.finish && !full_w) begin
            mem_x[node_cnt_reg[IDX_W-1:0]]   <= nx_reg;
            mem_y[node_cnt_reg[IDX_W-1:0]]   <= ny_reg;
            mem_z[node_cnt_reg[IDX_W-1:0]]   <= nz_reg;
            mem_lvl[node_cnt_reg[IDX_W-1:0]] <= depth_w;
        end
    end

    // entry 0 is the root, taken live from the start registers
    always_comb begin
        px1  = (idx1_reg == '0) ? cfg.start_x : rd_x_reg;
        py1  = (idx1_reg == '0) ? cfg.start_y : rd_y_reg;
        pz1  = (idx1_reg == '0) ? cfg.start_z : rd_z_reg;
        lvl1 = (idx1_reg == '0) ? LVL_W'(1) : rd_lvl_reg;
        dx1  = DIFF_W'(px1) - DIFF_W'(sx_reg);
        dy1  = DIFF_W'(py1) - DIFF_W'(sy_reg);
        dz1  = DIFF_W'(pz1) - DIFF_W'(sz_reg);
    end

    assign sum3 = sqx3_reg + sqy3_reg + sqz3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // abs differences, then squares, then compare
    always_ff @(posedge aclk) begin
        idx1_reg <= cmd.scan_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax2_reg  <= dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
        ay2_reg  <= dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);
        az2_reg  <= dz1[DIFF_W-1] ? DIFF_W'(-dz1) : DIFF_W'(dz1);
        px2_reg  <= px1;
        py2_reg  <= py1;
        pz2_reg  <= pz1;
        lvl2_reg <= lvl1;
        sqx3_reg <= SQ_W'(ax2_reg) * SQ_W'(ax2_reg);
        sqy3_reg <= SQ_W'(ay2_reg) * SQ_W'(ay2_reg);
        sqz3_reg <= SQ_W'(az2_reg) * SQ_W'(az2_reg);
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
        pz3_reg  <= pz2_reg;
        lvl3_reg <= lvl2_reg;
        // ties keep the lower index
        if (v3_reg && ((idx3_reg == '0) || (sum3 < best_d2_reg))) begin
            best_d2_reg  <= sum3;
            best_idx_reg <= idx3_reg;
            bx_reg       <= px3_reg;
            by_reg       <= py3_reg;
            bz_reg       <= pz3_reg;
            best_lvl_reg <= lvl3_reg;
        end
    end

    // digit-by-digit floor square root, two radicand bits per step
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg  <= best_d2_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // component select for the steering offset
    always_comb begin
        case (cmd.comp)
            COMP_X:  begin bsel = bx_reg; ssel = sx_reg; end
            COMP_Y:  begin bsel = by_reg; ssel = sy_reg; end
            COMP_Z:  begin bsel = bz_reg; ssel = sz_reg; end
            default: begin bsel = bx_reg; ssel = sx_reg; end
        endcase
        dsel = DIFF_W'(ssel) - DIFF_W'(bsel);
        asel = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
    end

    // restoring divide of |d|*step by the length, one quotient bit per step
    assign dtry = {drem_reg[DREM_W-2:0], dq_reg[PROD_W-1]};
    assign qs   = neg_reg ? -$signed({1'b0, dq_reg[DIFF_W-1:0]})
                          :  $signed({1'b0, dq_reg[DIFF_W-1:0]});
    assign nsum = $signed((DIFF_W+1)'(bsel)) + qs;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PROD_W'(asel) * PROD_W'(cfg.step_limit);
            neg_reg  <= dsel[DIFF_W-1];
        end
        if (cmd.div_load) begin
            dq_reg   <= prod_reg;
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            if (dtry >= DREM_W'(root_reg)) begin
                drem_reg <= dtry - DREM_W'(root_reg);
                dq_reg   <= {dq_reg[PROD_W-2:0], 1'b1};
            end else begin
                drem_reg <= dtry;
                dq_reg   <= {dq_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    // new point
    always_ff @(posedge aclk) begin
        if (cmd.copy_sample) begin
            nx_reg <= sx_reg;
            ny_reg <= sy_reg;
            nz_reg <= sz_reg;
        end else if (cmd.div_store) begin
            case (cmd.comp)
                COMP_X:  nx_reg <= nsum[COORD_W-1:0];
                COMP_Y:  ny_reg <= nsum[COORD_W-1:0];
                COMP_Z:  nz_reg <= nsum[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign full_w  = (node_cnt_reg >= CNT_W'(MAX_NODES));
    assign depth_w = (best_lvl_reg == LVL_MAX) ? LVL_MAX : best_lvl_reg + LVL_W'(1);
    assign hit_w   = (nx_reg >= cfg.goal_min_x) && (nx_reg <= cfg.goal_max_x) &&
                     (ny_reg >= cfg.goal_min_y) && (ny_reg <= cfg.goal_max_y);

    // node count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_cnt_reg <= CNT_W'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.finish && !full_w) begin
                node_cnt_reg <= node_cnt_reg + CNT_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_idx_reg   <= full_w ? '0 : OUT_IDX_W'(node_cnt_reg);
            o_par_reg   <= OUT_IDX_W'(best_idx_reg);
            o_x_reg     <= nx_reg;
            o_y_reg     <= ny_reg;
            o_z_reg     <= nz_reg;
            o_depth_reg <= depth_w;
            o_hit_reg   <= hit_w;
            o_full_reg  <= full_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_full_reg, o_hit_reg, o_depth_reg, o_z_reg, o_y_reg, o_x_reg,
                       o_par_reg, o_idx_reg};

    assign stat.node_cnt = node_cnt_reg;
    assign stat.steer    = (best_d2_reg > SQ_W'(lim2_reg));
    assign stat.out_busy = m_valid_reg && !m_tready;

    `RTE_ASSERT_IMP(a_cnt_range, 1'b1, (node_cnt_reg >= CNT_W'(1)) && (node_cnt_reg <= CNT_W'(MAX_NODES)), "node count out of range")
    `RTE_ASSERT_NXT(a_cnt_inc, cmd.finish && !full_w, node_cnt_reg == $past(node_cnt_reg) + CNT_W'(1), "node count did not advance on insert")
    `RTE_ASSERT_IMP(a_no_overwrite, cmd.finish, !(m_valid_reg && !m_tready), "result overwritten before transfer")

endmodule

// ===== rtl/rrt_tree_extend_top.sv =====
// Tree extend engine: each sample transfer (x, y, z in signed Q16.16) is matched against all
// stored nodes by squared distance, steered from the nearest one by at most step_limit, and the
// new node is appended and reported with its parent, depth and x-y goal box hit. One sample is
// handled at a time. The node count runs from 1 to 1024. The node scan reads one table entry per
// cycle from the node memory, and steering adds a 33-step square root and three 64-step divides
// on one shared divider. A finished result waits in an output register; once the table holds
// 1024 nodes, results carry table_full and nothing is stored.
module rrt_tree_extend_top
    import rte_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // sample_x, sample_y, sample_z from bit 0 up
    input  logic [95:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // new_index, parent_index, new_x, new_y, new_z, new_depth, goal_hit, table_full
    output logic [135:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    rte_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rte_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .sample_x (s_tdata[31:0]),
        .sample_y (s_tdata[63:32]),
        .sample_z (s_tdata[95:64]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
